// File: rtl/wtdp_pkg.sv
// shared constants and elaboration-time wheel helpers for the prime test unit
`default_nettype none
package wtdp_pkg;

   localparam int NUM_SMALL_PRIMES = 5;
   // residue table entry width, the largest modulus is 2310
   localparam int RES_W = 12;
   // index width into the small prime list
   localparam int KP_W = 3;

   typedef logic [3:0] prime_type;

   localparam prime_type SMALL_PRIMES [NUM_SMALL_PRIMES] = '{4'd2, 4'd3, 4'd5, 4'd7, 4'd11};

   function automatic int clamp_seed(int seed);
      int s;
      s = seed;
      if (s < 2) s = 2;
      if (s > 11) s = 11;
      return s;
   endfunction

   function automatic int prime_count(int seed);
      int n;
      n = 0;
      for (int i = 0; i < NUM_SMALL_PRIMES; i++) begin
         if (int'(SMALL_PRIMES[i]) <= seed) n++;
      end
      return n;
   endfunction

   function automatic int wheel_modulus(int seed);
      int m;
      m = 1;
      for (int i = 0; i < NUM_SMALL_PRIMES; i++) begin
         if (int'(SMALL_PRIMES[i]) <= seed) m = m * int'(SMALL_PRIMES[i]);
      end
      return m;
   endfunction

   function automatic bit is_coprime(int seed, int r);
      bit ok;
      int t;
      ok = 1'b1;
      for (int i = 0; i < NUM_SMALL_PRIMES; i++) begin
         if (int'(SMALL_PRIMES[i]) <= seed) begin
            // remainder by repeated subtraction, r stays below the modulus
            t = r;
            while (t >= int'(SMALL_PRIMES[i])) t = t - int'(SMALL_PRIMES[i]);
            if (t == 0) ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic int residue_count(int seed);
      int n;
      n = 0;
      for (int r = 1; r < wheel_modulus(seed); r++) begin
         if (is_coprime(seed, r)) n++;
      end
      return n;
   endfunction

   // k-th coprime residue in ascending order, 0 when there is none
   function automatic int residue_at(int seed, int k);
      int n;
      int v;
      n = 0;
      v = 0;
      for (int r = 1; r < wheel_modulus(seed); r++) begin
         if (is_coprime(seed, r)) begin
            if (n == k) v = r;
            n++;
         end
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/wheel_trial_division_prime_test_unit.sv
// wheel trial-division primality test with one shared compare-subtract unit
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, req_candidate     | taken when start && !busy
//  result   | rsp_valid, rsp_is_prime        | one-cycle strobe, no backpressure
//
// one request runs a classify state, a bit-serial remainder per wheel prime,
// ceil(XW/2) square-root steps, then a fetch, a bound check and a bit-serial
// remainder per wheel trial divisor up to isqrt+1; the bit-serial remainder on
// the shared subtractor dominates the run time.
// busy is high from the accepting edge until the result strobe.
// synchronous active-high reset returns the sequencer to idle; results
// cannot be stalled.
`default_nettype none
module wheel_trial_division_prime_test_unit
   import wtdp_pkg::*;
#(
   parameter int WHEEL_SEED  = 7,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_candidate,
   output logic             rsp_valid,
   output logic             rsp_is_prime
);

   localparam int SEED      = clamp_seed(WHEEL_SEED);
   localparam int NP        = prime_count(SEED);
   localparam int M         = wheel_modulus(SEED);
   localparam int NR        = residue_count(SEED);
   localparam int XW        = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
   localparam int DW        = XW + RES_W;
   localparam int RW        = DW + 1;
   localparam int CNT_W     = $clog2(XW);
   localparam int IDX_W     = (NR > 1) ? $clog2(NR) : 1;
   localparam int SQ_TOP    = ((XW - 1) / 2) * 2;
   localparam int FIRST_DIV = (NR > 1) ? residue_at(SEED, 1) : M + 1;
   localparam int IDX_START = (NR > 1) ? 1 : 0;
   localparam int BASE_START = (NR > 1) ? 0 : M;

   typedef logic [RES_W-1:0] res_table_type [NR];

   function automatic res_table_type build_table();
      res_table_type t;
      int k;
      t = '{default: '0};
      k = 0;
      for (int r = 1; r < M; r++) begin
         if (is_coprime(SEED, r)) begin
            t[k] = RES_W'(r);
            k++;
         end
      end
      return t;
   endfunction

   localparam res_table_type RES_TABLE = build_table();

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_MOD,
      ST_SQRT,
      ST_FETCH,
      ST_TRIAL
   } state_type;

   state_type        state_ff;
   logic [XW-1:0]    x_ff;
   logic [XW-1:0]    xs_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    div_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [KP_W-1:0]  kp_ff;
   logic             trial_ff;
   logic [XW-1:0]    v_ff;
   logic [XW-1:0]    root_ff;
   logic [XW-1:0]    bitm_ff;
   logic [DW-1:0]    bound_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [DW-1:0]    base_ff;
   logic             rsp_valid_ff;
   logic             rsp_prime_ff;

   // shared compare-subtract unit
   logic [RW-1:0] sub_a;
   logic [RW-1:0] sub_b;
   logic [RW-1:0] diff;
   logic          borrow;
   logic          ge;
   logic [DW-1:0] rem_step;
   logic [XW-1:0] root_step;
   logic          x_is_wheel;

   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = RW'(v_ff);
         sub_b = RW'(root_ff | bitm_ff);
      end else begin
         sub_a = {rem_ff, xs_ff[XW-1]};
         sub_b = {1'b0, div_ff};
      end
      {borrow, diff} = {1'b0, sub_a} - {1'b0, sub_b};
      ge = !borrow;
      rem_step  = ge ? diff[DW-1:0] : sub_a[DW-1:0];
      root_step = ge ? ((root_ff >> 1) | bitm_ff) : (root_ff >> 1);
   end

   always_comb begin
      x_is_wheel = 1'b0;
      for (int i = 0; i < NUM_SMALL_PRIMES; i++) begin
         if (i < NP && x_ff == XW'(SMALL_PRIMES[i])) x_is_wheel = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  x_ff     <= req_candidate[XW-1:0];
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               if (x_ff < XW'(2)) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else if (x_is_wheel) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  kp_ff    <= '0;
                  div_ff   <= DW'(SMALL_PRIMES[0]);
                  rem_ff   <= '0;
                  xs_ff    <= x_ff;
                  cnt_ff   <= CNT_W'(XW - 1);
                  trial_ff <= 1'b0;
                  state_ff <= ST_MOD;
               end
            end
            ST_MOD: begin
               if (cnt_ff != '0) begin
                  rem_ff <= rem_step;
                  xs_ff  <= xs_ff << 1;
                  cnt_ff <= cnt_ff - 1'b1;
               end else if (rem_step == '0) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end else if (trial_ff) begin
                  if (idx_ff == IDX_W'(NR - 1)) begin
                     idx_ff  <= '0;
                     base_ff <= base_ff + DW'(M);
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                  end
                  state_ff <= ST_FETCH;
               end else if (kp_ff == KP_W'(NP - 1)) begin
                  if (x_ff < XW'(FIRST_DIV)) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_prime_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end else begin
                     v_ff     <= x_ff;
                     root_ff  <= '0;
                     bitm_ff  <= XW'(1) << SQ_TOP;
                     state_ff <= ST_SQRT;
                  end
               end else begin
                  // next wheel prime
                  kp_ff  <= kp_ff + 1'b1;
                  div_ff <= DW'(SMALL_PRIMES[kp_ff + 1'b1]);
                  rem_ff <= '0;
                  xs_ff  <= x_ff;
                  cnt_ff <= CNT_W'(XW - 1);
               end
            end
            ST_SQRT: begin
               if (ge) v_ff <= diff[XW-1:0];
               root_ff <= root_step;
               bitm_ff <= bitm_ff >> 2;
               if (bitm_ff[0]) begin
                  bound_ff <= DW'(root_step) + 1'b1;
                  idx_ff   <= IDX_W'(IDX_START);
                  base_ff  <= DW'(BASE_START);
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               div_ff   <= base_ff + DW'(RES_TABLE[idx_ff]);
               state_ff <= ST_TRIAL;
            end
            ST_TRIAL: begin
               if (div_ff > bound_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  rem_ff   <= '0;
                  xs_ff    <= x_ff;
                  cnt_ff   <= CNT_W'(XW - 1);
                  trial_ff <= 1'b1;
                  state_ff <= ST_MOD;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

endmodule
`default_nettype wire
